// ===== hw/rtl/pcg_pkg.sv =====
package pcg_pkg;

    // Width of the generator state and of one operand limb of the shared multiplier.
    localparam int unsigned STATE_W = 128;
    localparam int unsigned LIMB_W  = 32;
    localparam int unsigned WORD_W  = 64;

    // Standard 128-bit multiplier and increment of the congruential step.
    localparam logic [STATE_W-1:0] LCG_MULT =
        {64'd2549297995355413924, 64'd4865540595714422341};
    localparam logic [STATE_W-1:0] LCG_INC =
        {64'd6364136223846793005, 64'd1442695040888963407};

    // Command codes carried in the cmd field.
    typedef enum logic [1:0] {
        CMD_GENERATE = 2'd0,
        CMD_SEED     = 2'd1,
        CMD_ADVANCE  = 2'd2
    } cmd_t;

endpackage

// ===== hw/rtl/pcg_xsl_rr_128_64_generator_core.sv =====
// PCG random generator, 128-bit congruential state with XSL-RR 64-bit output.
// Input channel (in_valid/in_stall) carries one word: cmd, operand_lo, operand_hi.
// A generate command steps the state and returns one 64-bit word on the output
// channel (out_valid/out_stall); seed and advance return nothing, nor does the
// unused command code.
// Every 128-bit product runs through one 32x32 multiplier that works through
// the ten limb products of the low half.
// Generate and seed each run one state step. Advance walks the count bit by
// bit up to its highest set bit, with more products for a set bit than for a
// clear one, and then applies the result to the state with a final product;
// an advance of zero runs only that final product.
// in_stall is high while a command is at work. A finished result sits in the
// output register; if it has not been taken when the next generate completes,
// the block holds that step until the output register frees.
// Reset clears the state to zero and empties the output register.
module pcg_xsl_rr_128_64_generator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [63:0] operand_lo,
    input  logic [63:0] operand_hi,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] random_value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADV_CHECK,
        S_LAUNCH,
        S_MUL,
        S_DRAIN,
        S_WB
    } state_t;

    typedef enum logic [2:0] {
        PH_GEN,
        PH_SEED,
        PH_ACC_M,
        PH_ACC_A,
        PH_CUR_A,
        PH_CUR_M,
        PH_FINAL
    } phase_t;

    state_t state_reg;
    phase_t phase_reg;

    logic [pcg_pkg::STATE_W-1:0] lcg_reg;
    logic [pcg_pkg::STATE_W-1:0] cur_m_reg;
    logic [pcg_pkg::STATE_W-1:0] cur_a_reg;
    logic [pcg_pkg::STATE_W-1:0] acc_m_reg;
    logic [pcg_pkg::STATE_W-1:0] acc_a_reg;
    logic [pcg_pkg::WORD_W-1:0]  count_reg;

    // Shared multiply-accumulate unit: acc = x * y + z, modulo 2^128.
    logic [pcg_pkg::STATE_W-1:0] x_reg;
    logic [pcg_pkg::STATE_W-1:0] y_reg;
    logic [pcg_pkg::STATE_W-1:0] acc_reg;
    logic [1:0]                  i_reg;
    logic [1:0]                  j_reg;
    logic [1:0]                  sh_reg;
    logic [2*pcg_pkg::LIMB_W-1:0] prod_reg;
    logic                        pv_reg;

    logic                        out_valid_reg;
    logic [pcg_pkg::WORD_W-1:0]  random_value_reg;

    logic [pcg_pkg::LIMB_W-1:0]   x_limb;
    logic [pcg_pkg::LIMB_W-1:0]   y_limb;
    logic [2*pcg_pkg::LIMB_W-1:0] prod_next;
    logic [pcg_pkg::STATE_W-1:0]  acc_next;
    logic                         last_pair;
    logic                         j_wrap;
    logic                         accept;
    logic                         out_free;
    logic                         wb_gen_done;
    logic [pcg_pkg::STATE_W-1:0]  op_x;
    logic [pcg_pkg::STATE_W-1:0]  op_y;
    logic [pcg_pkg::STATE_W-1:0]  op_z;
    logic [pcg_pkg::WORD_W-1:0]   fold_word;
    logic [5:0]                   rot_amt;
    logic [2*pcg_pkg::WORD_W-1:0] rot_pair;
    logic [pcg_pkg::WORD_W-1:0]   rand_next;

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign random_value = random_value_reg;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // A generate step writes back once the output register can take its word.
    assign wb_gen_done = (state_reg == S_WB) && (phase_reg == PH_GEN) && out_free;

    // Limb product of the pair in hand and its weighted accumulation.
    assign x_limb    = x_reg[{i_reg, 5'b0} +: pcg_pkg::LIMB_W];
    assign y_limb    = y_reg[{j_reg, 5'b0} +: pcg_pkg::LIMB_W];
    assign prod_next = x_limb * y_limb;
    assign acc_next  = acc_reg + ({64'b0, prod_reg} << {sh_reg, 5'b0});

    // Only limb pairs whose weight stays below 2^128 are visited.
    assign j_wrap    = (j_reg == (2'd3 - i_reg));
    assign last_pair = (i_reg == 2'd3);

    // Operands of the next product, chosen by the phase of the command.
    always_comb
    begin
        unique case (phase_reg)
            PH_GEN, PH_SEED:
            begin
                op_x = lcg_reg;
                op_y = pcg_pkg::LCG_MULT;
                op_z = pcg_pkg::LCG_INC;
            end
            PH_ACC_M:
            begin
                op_x = acc_m_reg;
                op_y = cur_m_reg;
                op_z = '0;
            end
            PH_ACC_A:
            begin
                op_x = acc_a_reg;
                op_y = cur_m_reg;
                op_z = cur_a_reg;
            end
            PH_CUR_A:
            begin
                op_x = cur_m_reg + 128'd1;
                op_y = cur_a_reg;
                op_z = '0;
            end
            PH_CUR_M:
            begin
                op_x = cur_m_reg;
                op_y = cur_m_reg;
                op_z = '0;
            end
            PH_FINAL:
            begin
                op_x = acc_m_reg;
                op_y = lcg_reg;
                op_z = acc_a_reg;
            end
            default:
            begin
                op_x = '0;
                op_y = '0;
                op_z = '0;
            end
        endcase
    end

    // Output permutation: fold the halves and rotate by the top six state bits.
    assign fold_word = acc_reg[127:64] ^ acc_reg[63:0];
    assign rot_amt   = acc_reg[127:122];
    assign rot_pair  = {fold_word, fold_word} >> rot_amt;
    assign rand_next = rot_pair[pcg_pkg::WORD_W-1:0];

    // Sequencer, datapath registers and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_GEN;
            lcg_reg       <= '0;
            out_valid_reg <= 1'b0;
            pv_reg        <= 1'b0;
        end
        else
        begin
            // The output register fills on a generate write-back and empties when taken.
            if (wb_gen_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (cmd)
                            pcg_pkg::CMD_GENERATE:
                            begin
                                phase_reg <= PH_GEN;
                                state_reg <= S_LAUNCH;
                            end
                            pcg_pkg::CMD_SEED:
                            begin
                                // A step from the zero state leaves the increment.
                                lcg_reg   <= pcg_pkg::LCG_INC + {operand_hi, operand_lo};
                                phase_reg <= PH_SEED;
                                state_reg <= S_LAUNCH;
                            end
                            pcg_pkg::CMD_ADVANCE:
                            begin
                                cur_m_reg <= pcg_pkg::LCG_MULT;
                                cur_a_reg <= pcg_pkg::LCG_INC;
                                acc_m_reg <= 128'd1;
                                acc_a_reg <= '0;
                                count_reg <= operand_lo;
                                state_reg <= S_ADV_CHECK;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_ADV_CHECK:
                begin
                    priority if (count_reg == '0)
                    begin
                        phase_reg <= PH_FINAL;
                    end
                    else if (count_reg[0])
                    begin
                        phase_reg <= PH_ACC_M;
                    end
                    else
                    begin
                        phase_reg <= PH_CUR_A;
                    end
                    state_reg <= S_LAUNCH;
                end
                S_LAUNCH:
                begin
                    x_reg     <= op_x;
                    y_reg     <= op_y;
                    acc_reg   <= op_z;
                    i_reg     <= 2'd0;
                    j_reg     <= 2'd0;
                    pv_reg    <= 1'b0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg <= prod_next;
                    sh_reg   <= i_reg + j_reg;
                    pv_reg   <= 1'b1;
                    if (pv_reg)
                    begin
                        acc_reg <= acc_next;
                    end
                    if (j_wrap)
                    begin
                        j_reg <= 2'd0;
                        i_reg <= i_reg + 2'd1;
                    end
                    else
                    begin
                        j_reg <= j_reg + 2'd1;
                    end
                    if (last_pair)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    acc_reg   <= acc_next;
                    pv_reg    <= 1'b0;
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    unique case (phase_reg)
                        PH_GEN:
                        begin
                            if (out_free)
                            begin
                                lcg_reg          <= acc_reg;
                                random_value_reg <= rand_next;
                                state_reg        <= S_IDLE;
                            end
                        end
                        PH_SEED, PH_FINAL:
                        begin
                            lcg_reg   <= acc_reg;
                            state_reg <= S_IDLE;
                        end
                        PH_ACC_M:
                        begin
                            acc_m_reg <= acc_reg;
                            phase_reg <= PH_ACC_A;
                            state_reg <= S_LAUNCH;
                        end
                        PH_ACC_A:
                        begin
                            acc_a_reg <= acc_reg;
                            phase_reg <= PH_CUR_A;
                            state_reg <= S_LAUNCH;
                        end
                        PH_CUR_A:
                        begin
                            cur_a_reg <= acc_reg;
                            phase_reg <= PH_CUR_M;
                            state_reg <= S_LAUNCH;
                        end
                        PH_CUR_M:
                        begin
                            cur_m_reg <= acc_reg;
                            count_reg <= count_reg >> 1;
                            state_reg <= S_ADV_CHECK;
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A new result word only appears from the write-back of a generate step.
    a_out_from_generate: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_WB && phase_reg == PH_GEN))
        else $error("result word raised outside a generate write-back");

    // The drain cycle always follows the last limb product.
    a_drain_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL && last_pair) |=> (state_reg == S_DRAIN && pv_reg))
        else $error("multiplier did not drain after the last limb pair");

    // A live command keeps the input stalled on the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == pcg_pkg::CMD_GENERATE || cmd == pcg_pkg::CMD_SEED
                    || cmd == pcg_pkg::CMD_ADVANCE)) |=> in_stall)
        else $error("command accepted without occupying the block");

    // A pending result word is never overwritten by a later generate.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(random_value_reg))
        else $error("pending result word overwritten");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // The one code the package leaves unnamed; the block ignores it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned IDLE_LIMIT  = 20000;

    // Tracks the generator state and the values it owes the output channel.
    class pcg_scoreboard;
        logic [pcg_pkg::STATE_W-1:0] lcg_state;
        logic [pcg_pkg::WORD_W-1:0]  expected_values[$];
        int                          errors;

        function new();
            lcg_state = '0;
            errors    = 0;
        endfunction

        // One congruential step, modulo 2^128.
        function void lcg_step_state();
            lcg_state = lcg_state * pcg_pkg::LCG_MULT + pcg_pkg::LCG_INC;
        endfunction

        // High word XOR low word, rotated right by the top six state bits.
        function logic [pcg_pkg::WORD_W-1:0] xsl_rr_fold(logic [pcg_pkg::STATE_W-1:0] s);
            logic [pcg_pkg::WORD_W-1:0]   folded;
            logic [2*pcg_pkg::WORD_W-1:0] doubled;
            folded  = s[127:64] ^ s[63:0];
            doubled = {folded, folded} >> s[127:122];
            return doubled[63:0];
        endfunction

        // Jump ahead by composing the affine step with itself, one count bit at a time.
        function void jump_ahead(logic [pcg_pkg::WORD_W-1:0] count);
            logic [pcg_pkg::STATE_W-1:0] step_scale;
            logic [pcg_pkg::STATE_W-1:0] cur_inc;
            logic [pcg_pkg::STATE_W-1:0] total_scale;
            logic [pcg_pkg::STATE_W-1:0] acc_inc;
            step_scale  = pcg_pkg::LCG_MULT;
            cur_inc     = pcg_pkg::LCG_INC;
            total_scale = 128'd1;
            acc_inc     = '0;
            for (int i = 0; i < pcg_pkg::WORD_W; i++)
            begin
                if (count[i])
                begin
                    total_scale = total_scale * step_scale;
                    acc_inc     = acc_inc * step_scale + cur_inc;
                end
                cur_inc    = (step_scale + 128'd1) * cur_inc;
                step_scale = step_scale * step_scale;
            end
            lcg_state = total_scale * lcg_state + acc_inc;
        endfunction

        // Apply an accepted input word to the predicted state.
        function void note_word(logic [1:0] c, logic [pcg_pkg::WORD_W-1:0] lo,
                                logic [pcg_pkg::WORD_W-1:0] hi);
            if (c == pcg_pkg::CMD_GENERATE)
            begin
                lcg_step_state();
                expected_values.push_back(xsl_rr_fold(lcg_state));
            end
            else if (c == pcg_pkg::CMD_SEED)
            begin
                lcg_state = '0;
                lcg_step_state();
                lcg_state = lcg_state + {hi, lo};
                lcg_step_state();
            end
            else if (c == pcg_pkg::CMD_ADVANCE)
            begin
                jump_ahead(lo);
            end
        endfunction

        // Compare an accepted output word with the oldest value owed.
        function void check_value(logic [pcg_pkg::WORD_W-1:0] got);
            logic [pcg_pkg::WORD_W-1:0] want;
            if (expected_values.size() == 0)
            begin
                $display("%0t: random_value %h arrived with no value expected", $time, got);
                errors++;
            end
            else
            begin
                want = expected_values.pop_front();
                if (got !== want)
                begin
                    $display("%0t: random_value mismatch, expected %h, got %h",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_values.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = pcg_pkg::CMD_GENERATE;
    logic [63:0] operand_lo = '0;
    logic [63:0] operand_hi = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] random_value;

    pcg_scoreboard sb;
    int          idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_token = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;

    pcg_xsl_rr_128_64_generator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .operand_lo   (operand_lo),
        .operand_hi   (operand_hi),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_value (random_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output side: check every accepted word, then choose the next stall.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_value(random_value);
        if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Watchdog: give up once neither channel has moved a word for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("pcg_xsl_rr_128_64_generator_core regression: fail");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Advance counts are mostly short, since each count bit adds multiplier products.
    function automatic logic [63:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return rand64();
        else if (r < 10)
            return 64'($urandom_range(0, 3));
        else
            return rand64() >> $urandom_range(52, 63);
    endfunction

    // Offer one input word, idling first at the current rate, and wait for it to be taken.
    task automatic offer_word(input logic [1:0] c, input logic [63:0] lo, input logic [63:0] hi);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        operand_lo <= lo;
        operand_hi <= hi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(c, lo, hi);
    endtask

    // Random command mix; reports whether the word does anything.
    task automatic offer_random_word(output bit useful);
        logic [1:0]  c;
        logic [63:0] lo;
        int          r;
        r  = $urandom_range(0, 99);
        lo = rand64();
        if (r < 60)
            c = pcg_pkg::CMD_GENERATE;
        else if (r < 75)
            c = pcg_pkg::CMD_SEED;
        else if (r < 93)
        begin
            c  = pcg_pkg::CMD_ADVANCE;
            lo = pick_count();
        end
        else
            c = CMD_UNUSED;
        offer_word(c, lo, rand64());
        useful = (c != CMD_UNUSED);
    endtask

    task automatic run_phase(input int sender_idle, input int receiver_stall, input int words);
        int n;
        bit useful;
        n         = 0;
        idle_pct  = sender_idle;
        stall_pct <= receiver_stall;
        while (n < words)
        begin
            offer_random_word(useful);
            if (useful)
                n++;
        end
    endtask

    // Stop offering until every owed value has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: the zero state, the unused code, seed and advance extremes.
        offer_word(pcg_pkg::CMD_GENERATE, '0, '0);
        offer_word(pcg_pkg::CMD_GENERATE, '0, '0);
        offer_word(CMD_UNUSED, rand64(), rand64());
        offer_word(pcg_pkg::CMD_GENERATE, '0, '0);
        offer_word(pcg_pkg::CMD_SEED, '0, '0);
        offer_word(pcg_pkg::CMD_GENERATE, '0, '0);
        offer_word(pcg_pkg::CMD_SEED, '1, '1);
        offer_word(pcg_pkg::CMD_GENERATE, '1, '1);
        offer_word(pcg_pkg::CMD_ADVANCE, '0, '1);
        offer_word(pcg_pkg::CMD_GENERATE, '0, '0);
        offer_word(pcg_pkg::CMD_ADVANCE, 64'd1, '0);
        offer_word(pcg_pkg::CMD_GENERATE, '0, '0);
        offer_word(pcg_pkg::CMD_ADVANCE, '1, '0);
        offer_word(pcg_pkg::CMD_GENERATE, '0, '0);
        offer_word(pcg_pkg::CMD_ADVANCE, 64'h8000_0000_0000_0000, rand64());
        offer_word(pcg_pkg::CMD_GENERATE, '0, '0);
        offer_word(pcg_pkg::CMD_SEED, rand64(), rand64());
        offer_word(pcg_pkg::CMD_ADVANCE, 64'd2, '0);
        offer_word(pcg_pkg::CMD_GENERATE, rand64(), rand64());
        offer_word(pcg_pkg::CMD_GENERATE, '0, '0);
        offer_word(pcg_pkg::CMD_GENERATE, '0, '0);
        wait_drained();

        run_phase(0, 0, 280);

        // Long receiver hold-off while generate words keep coming, so the block backs up.
        hold_token <= ~hold_token;
        for (int i = 0; i < 16; i++)
            offer_word(pcg_pkg::CMD_GENERATE, rand64(), rand64());
        wait_drained();

        run_phase(80, 0, 280);
        wait_drained();
        run_phase(0, 80, 280);
        run_phase(34, 34, 280);
        wait_drained();
        run_phase(0, 0, 280);

        // Drain, let any advance finish, and watch for stray output words.
        in_valid  <= 1'b0;
        stall_pct <= 0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        while (in_stall)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("pcg_xsl_rr_128_64_generator_core regression: pass");
        else
            $display("pcg_xsl_rr_128_64_generator_core regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pcg_pkg.sv
hw/rtl/pcg_xsl_rr_128_64_generator_core.sv
tb/tb_top.sv
